// File: sv/oaht_pkg.sv
// Shared types, widths and codes of the open-addressing hash table.
package oaht_pkg;

  // Default table size and fixed field widths.
  localparam int unsigned SLOTS_DEF = 256;
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned KEY_W     = 32;
  localparam int unsigned HASH_W    = 32;
  localparam int unsigned VAL_W     = 64;
  localparam int unsigned STS_W     = 2;
  localparam int unsigned LIM_W     = 8;
  localparam int unsigned CNT_W     = 9;

  // Load limit after reset and the largest value it can take.
  localparam logic [LIM_W-1:0] LIMIT_RST = 8'd192;
  localparam int unsigned      LIM_MAX   = 255;

  // Hash reduction: bits handled per step and number of steps.
  localparam int unsigned MOD_BITS  = 4;
  localparam int unsigned MOD_STEPS = HASH_W / MOD_BITS;
  localparam int unsigned MOD_CNT_W = $clog2(MOD_STEPS + 1);

  // Commands carried by an input word.
  typedef enum logic [CMD_W-1:0] {
    CMD_SET = 2'd0,
    CMD_GET = 2'd1,
    CMD_DEL = 2'd2,
    CMD_CLR = 2'd3
  } cmd_e;

  // Result status codes.
  typedef enum logic [STS_W-1:0] {
    ST_OK     = 2'd0,
    ST_ABSENT = 2'd1,
    ST_FULL   = 2'd2
  } status_e;

  // Per-slot occupancy held in the slot state memory.
  typedef enum logic [1:0] {
    SL_EMPTY = 2'b00,
    SL_LIVE  = 2'b01,
    SL_TOMB  = 2'b10
  } slot_e;

  // Controller states.
  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_MOD,
    S_PROBE,
    S_CLEAR,
    S_FINISH
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic in_ready;
    logic mod_step;
    logic issue;
    logic advance;
    logic capture;
    logic clear_step;
    logic commit;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_valid;
    cmd_e op;
    logic skip;
    logic mod_done;
    logic probe_stop;
    logic clr_last;
    logic out_free;
  } dp_sts_t;

endpackage

// File: sv/oaht_if.sv
// Request and response channel interfaces of the hash table.
interface oaht_req_if;
  logic                          valid;
  logic                          ready;
  logic [oaht_pkg::CMD_W-1:0]    cmd;
  logic [oaht_pkg::KEY_W-1:0]    key_id;
  logic [oaht_pkg::HASH_W-1:0]   key_hash;
  logic [oaht_pkg::VAL_W-1:0]    set_value;

  modport source (output valid, cmd, key_id, key_hash, set_value, input ready);
  modport sink (input valid, cmd, key_id, key_hash, set_value, output ready);
endinterface

interface oaht_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [oaht_pkg::STS_W-1:0]    status;
  logic                          new_key;
  logic [oaht_pkg::VAL_W-1:0]    found_value;

  modport source (output valid, status, new_key, found_value, input ready);
  modport sink (input valid, status, new_key, found_value, output ready);
endinterface

// File: sv/oaht_ctrl.sv
// Controller state machine that sequences decode, hash reduction, probing and clearing.
module oaht_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  oaht_pkg::dp_sts_t     sts_i,
  output oaht_pkg::ctrl_cmd_t   cmd_o
);

  oaht_pkg::state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= oaht_pkg::S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      oaht_pkg::S_INIT: begin
        // Sweep the slot state memory empty after reset.
        cmd_o.clear_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = oaht_pkg::S_IDLE;
        end
      end
      oaht_pkg::S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (sts_i.in_valid) begin
          state_d = oaht_pkg::S_MOD;
        end
      end
      oaht_pkg::S_MOD: begin
        // Decode the command; once the start slot is known, issue its read.
        priority if (sts_i.op == oaht_pkg::CMD_CLR) begin
          state_d = oaht_pkg::S_CLEAR;
        end else if (sts_i.skip) begin
          state_d = oaht_pkg::S_FINISH;
        end else if (sts_i.mod_done) begin
          cmd_o.issue = 1'b1;
          state_d     = oaht_pkg::S_PROBE;
        end else begin
          cmd_o.mod_step = 1'b1;
        end
      end
      oaht_pkg::S_PROBE: begin
        if (sts_i.probe_stop) begin
          cmd_o.capture = 1'b1;
          state_d       = oaht_pkg::S_FINISH;
        end else begin
          cmd_o.advance = 1'b1;
        end
      end
      oaht_pkg::S_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = oaht_pkg::S_FINISH;
        end
      end
      oaht_pkg::S_FINISH: begin
        // Update the table and hand the result word to the output register.
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = oaht_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = oaht_pkg::S_INIT;
      end
    endcase
  end

endmodule

// File: sv/oaht_dp.sv
// Datapath: slot memories, hash reduction, probe tracking, counters and output register.
module oaht_dp #(
  parameter int unsigned SLOTS = oaht_pkg::SLOTS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [oaht_pkg::LIM_W-1:0]   cfg_wdata_i,
  oaht_req_if.sink                     req,
  oaht_rsp_if.source                   rsp,
  input  oaht_pkg::ctrl_cmd_t          cmd_i,
  output oaht_pkg::dp_sts_t            sts_o
);

  localparam int unsigned   IW       = $clog2(SLOTS);
  localparam bit            POW2     = (SLOTS & (SLOTS - 1)) == 0;
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);
  localparam logic [IW:0]   SLOTS_X  = (IW + 1)'(SLOTS);

  // Slot memories.
  oaht_pkg::slot_e                 st_mem  [SLOTS];
  logic [oaht_pkg::KEY_W-1:0]      key_mem [SLOTS];
  logic [oaht_pkg::VAL_W-1:0]      val_mem [SLOTS];

  oaht_pkg::slot_e                 rd_st_q;
  logic [oaht_pkg::KEY_W-1:0]      rd_key_q;
  logic [oaht_pkg::VAL_W-1:0]      rd_val_q;

  // Latched input word.
  oaht_pkg::cmd_e                  op_q;
  logic [oaht_pkg::KEY_W-1:0]      key_q;
  logic [oaht_pkg::VAL_W-1:0]      val_q;
  logic [oaht_pkg::HASH_W-1:0]     hsh_q;

  // Hash reduction.
  logic [IW-1:0]                   rem_q, rem_d;
  logic [IW:0]                     mod_t;
  logic [oaht_pkg::MOD_CNT_W-1:0]  mcnt_q;
  logic [IW-1:0]                   start_idx;
  logic                            mod_done;

  // Probe tracking and captured probe result.
  logic [IW-1:0]                   idx_q, idx_inc, raddr;
  logic [IW-1:0]                   n_q;
  logic                            have_tomb_q;
  logic [IW-1:0]                   tomb_idx_q;
  logic                            res_hit_q, res_have_q, res_tomb_q;
  logic [IW-1:0]                   res_where_q;
  logic [oaht_pkg::VAL_W-1:0]      res_val_q;

  logic                            live, tomb_now, empty, hit, last;
  logic                            probe_stop, have_where, where_tomb;
  logic [IW-1:0]                   where;

  // Counters and configuration.
  logic [IW-1:0]                   clr_q;
  logic                            clr_last;
  logic [oaht_pkg::CNT_W-1:0]      cnt_q;
  logic [oaht_pkg::LIM_W-1:0]      lim_q;
  logic                            skip;

  // Result of the finishing step.
  oaht_pkg::status_e               c_status;
  logic                            c_new;
  logic [oaht_pkg::VAL_W-1:0]      c_found;
  logic                            set_wr, del_wr, cnt_inc;

  // Memory write port.
  logic                            st_we, kv_we;
  logic [IW-1:0]                   st_wa;
  oaht_pkg::slot_e                 st_wd;

  // Output register.
  logic                            out_valid_q;
  oaht_pkg::status_e               out_status_q;
  logic                            out_new_q;
  logic [oaht_pkg::VAL_W-1:0]      out_found_q;
  logic                            out_free;
  logic                            accept;

  assign accept = req.valid && req.ready;

  // One remainder step: shift in MOD_BITS hash bits, subtract SLOTS where it fits.
  always_comb begin
    rem_d = rem_q;
    mod_t = '0;
    for (int j = 0; j < oaht_pkg::MOD_BITS; j++) begin
      mod_t = {rem_d, hsh_q[oaht_pkg::HASH_W-1-j]};
      if (mod_t >= SLOTS_X) begin
        mod_t = mod_t - SLOTS_X;
      end
      rem_d = mod_t[IW-1:0];
    end
  end

  assign start_idx = POW2 ? hsh_q[IW-1:0] : rem_q;
  assign mod_done  = POW2 || (mcnt_q == oaht_pkg::MOD_CNT_W'(oaht_pkg::MOD_STEPS));

  // Read address: the start slot on issue, otherwise the slot after the current one.
  assign idx_inc = (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
  assign raddr   = cmd_i.issue ? start_idx : idx_inc;

  // Evaluation of the slot whose contents came back this cycle.
  assign live       = rd_st_q == oaht_pkg::SL_LIVE;
  assign tomb_now   = rd_st_q == oaht_pkg::SL_TOMB;
  assign empty      = !live && !tomb_now;
  assign hit        = live && (rd_key_q == key_q);
  assign last       = n_q == LAST_IDX;
  assign probe_stop = hit || empty || last;
  assign have_where = hit || empty || have_tomb_q || tomb_now;
  assign where      = (!hit && have_tomb_q) ? tomb_idx_q : idx_q;
  assign where_tomb = !hit && (have_tomb_q || tomb_now);

  // Early answers that need no probe.
  always_comb begin
    unique case (op_q)
      oaht_pkg::CMD_SET: skip = ({1'b0, cnt_q} + 1'b1) > (oaht_pkg::CNT_W + 1)'(lim_q);
      oaht_pkg::CMD_GET: skip = cnt_q == '0;
      oaht_pkg::CMD_DEL: skip = cnt_q == '0;
      oaht_pkg::CMD_CLR: skip = 1'b0;
    endcase
  end

  // Result word and table update of the finishing step.
  always_comb begin
    c_status = oaht_pkg::ST_OK;
    c_new    = 1'b0;
    c_found  = '0;
    set_wr   = 1'b0;
    del_wr   = 1'b0;
    cnt_inc  = 1'b0;
    unique case (op_q)
      oaht_pkg::CMD_SET: begin
        if (skip || !res_have_q) begin
          c_status = oaht_pkg::ST_FULL;
        end else begin
          set_wr  = 1'b1;
          c_new   = !res_hit_q;
          cnt_inc = !res_hit_q && !res_tomb_q;
        end
      end
      oaht_pkg::CMD_GET: begin
        if (!skip && res_hit_q) begin
          c_found = res_val_q;
        end else begin
          c_status = oaht_pkg::ST_ABSENT;
        end
      end
      oaht_pkg::CMD_DEL: begin
        if (!skip && res_hit_q) begin
          del_wr = 1'b1;
        end else begin
          c_status = oaht_pkg::ST_ABSENT;
        end
      end
      oaht_pkg::CMD_CLR: begin
        c_status = oaht_pkg::ST_OK;
      end
    endcase
  end

  // Memory write port shared by the clearing sweep and the finishing step.
  assign st_we = cmd_i.clear_step || (cmd_i.commit && (set_wr || del_wr));
  assign st_wa = cmd_i.clear_step ? clr_q : res_where_q;
  assign st_wd = cmd_i.clear_step ? oaht_pkg::SL_EMPTY :
                 (set_wr ? oaht_pkg::SL_LIVE : oaht_pkg::SL_TOMB);
  assign kv_we = cmd_i.commit && set_wr;

  always_ff @(posedge clk_i) begin
    if (st_we) begin
      st_mem[st_wa] <= st_wd;
    end
    rd_st_q <= st_mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (kv_we) begin
      key_mem[res_where_q] <= key_q;
      val_mem[res_where_q] <= val_q;
    end
    rd_key_q <= key_mem[raddr];
    rd_val_q <= val_mem[raddr];
  end

  // Input word, hash reduction and probe tracking.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= oaht_pkg::cmd_e'(req.cmd);
      key_q  <= req.key_id;
      val_q  <= req.set_value;
      hsh_q  <= req.key_hash;
      rem_q  <= '0;
      mcnt_q <= '0;
    end else if (cmd_i.mod_step) begin
      hsh_q  <= hsh_q << oaht_pkg::MOD_BITS;
      rem_q  <= rem_d;
      mcnt_q <= mcnt_q + 1'b1;
    end
    if (cmd_i.issue) begin
      idx_q       <= start_idx;
      n_q         <= '0;
      have_tomb_q <= 1'b0;
    end else if (cmd_i.advance) begin
      idx_q <= idx_inc;
      n_q   <= n_q + 1'b1;
      if (tomb_now && !have_tomb_q) begin
        have_tomb_q <= 1'b1;
        tomb_idx_q  <= idx_q;
      end
    end
    if (cmd_i.capture) begin
      res_hit_q   <= hit;
      res_have_q  <= have_where;
      res_tomb_q  <= where_tomb;
      res_where_q <= where;
      res_val_q   <= rd_val_q;
    end
    if (cmd_i.commit) begin
      out_status_q <= c_status;
      out_new_q    <= c_new;
      out_found_q  <= c_found;
    end
  end

  // Clearing sweep counter; it always comes back to slot zero.
  assign clr_last = clr_q == LAST_IDX;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      cnt_q       <= '0;
      lim_q       <= oaht_pkg::LIMIT_RST;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear_step) begin
        clr_q <= clr_last ? '0 : clr_q + 1'b1;
      end
      if (cmd_i.commit && (op_q == oaht_pkg::CMD_CLR)) begin
        cnt_q <= '0;
      end else if (cmd_i.commit && cnt_inc) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (cfg_we_i) begin
        lim_q <= cfg_wdata_i;
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_free = !out_valid_q || rsp.ready;

  // Channel and status connections.
  assign req.ready       = cmd_i.in_ready;
  assign rsp.valid       = out_valid_q;
  assign rsp.status      = out_status_q;
  assign rsp.new_key     = out_new_q;
  assign rsp.found_value = out_found_q;

  assign sts_o.in_valid   = req.valid;
  assign sts_o.op         = op_q;
  assign sts_o.skip       = skip;
  assign sts_o.mod_done   = mod_done;
  assign sts_o.probe_stop = probe_stop;
  assign sts_o.clr_last   = clr_last;
  assign sts_o.out_free   = out_free;

  // The finishing step never overwrites a result word that is still waiting.
  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> out_free)
    else $error("result word overwritten before it was taken");

  // A probe never steps past its last slot.
  a_probe_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.advance |-> !last)
    else $error("probe advanced beyond the table size");

  // The slot count never exceeds the largest load limit.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= oaht_pkg::CNT_W'(oaht_pkg::LIM_MAX))
    else $error("slot count above the largest load limit");

  // A result word appears only after a finishing step.
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_i.commit))
    else $error("result word without a finishing step");

endmodule

// File: sv/open_addressing_hash_table.sv
// Top level: open-addressing hash table with linear probing and tombstones.
// Sequence: accept in S_IDLE, decode in S_MOD, probe slot by slot in S_PROBE, then finish;
// a table of SLOTS not a power of two adds MOD_STEPS steps of hash reduction in S_MOD.
// A new word is taken only in S_IDLE, after the previous word has finished.
// Clear empties the slot state memory, one slot cleared per cycle.
// Reset: asynchronous, active low; a clearing pass over every slot follows, ready held low.
module open_addressing_hash_table #(
  parameter int unsigned SLOTS = oaht_pkg::SLOTS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [oaht_pkg::LIM_W-1:0]  cfg_wdata_i,
  oaht_req_if.sink                    req_i,
  oaht_rsp_if.source                  rsp_o
);

  oaht_pkg::ctrl_cmd_t ctrl_cmd;
  oaht_pkg::dp_sts_t   dp_sts;

  // Sequencing.
  oaht_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (dp_sts),
    .cmd_o  (ctrl_cmd)
  );

  // Storage and arithmetic.
  oaht_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req         (req_i),
    .rsp         (rsp_o),
    .cmd_i       (ctrl_cmd),
    .sts_o       (dp_sts)
  );

endmodule

// File: sim/oaht_table_check.sv
// Checker for the hash table: shadow table, expected reply store and comparison.
`timescale 1ns / 1ps

module oaht_table_check
  import oaht_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [LIM_W-1:0] cfg_wdata_i,
  oaht_req_if              req_if,
  oaht_rsp_if              rsp_if,
  output int               fail_count_o,
  output int               pending_o
);

  localparam int unsigned TABLE_SLOTS = SLOTS_DEF;

  // One expected reply word.
  typedef struct {
    status_e           status;
    logic              new_key;
    logic [VAL_W-1:0]  found_value;
  } table_reply_t;

  // Shadow copy of the table contents, the fill count and the load limit.
  logic              shadow_live [TABLE_SLOTS];
  logic              shadow_tomb [TABLE_SLOTS];
  logic [KEY_W-1:0]  shadow_key  [TABLE_SLOTS];
  logic [VAL_W-1:0]  shadow_val  [TABLE_SLOTS];
  logic [CNT_W-1:0]  shadow_fill;
  logic [LIM_W-1:0]  shadow_limit;

  table_reply_t      expected_replies [$];
  table_reply_t      oldest;
  int                mismatches;

  assign fail_count_o = mismatches;

  // Empty every slot and zero the fill count.
  function automatic void wipe_table();
    for (int s = 0; s < TABLE_SLOTS; s++) begin
      shadow_live[s] = 1'b0;
      shadow_tomb[s] = 1'b0;
      shadow_key[s]  = '0;
      shadow_val[s]  = '0;
    end
    shadow_fill = '0;
  endfunction

  // Walk the table from the home slot. A hit is a live slot holding the key;
  // otherwise the slot for a set is the first tombstone passed, else the
  // first empty slot, and none may exist when the walk covers the whole table.
  function automatic void locate(input logic [KEY_W-1:0] key, input logic [HASH_W-1:0] hash,
                                 output logic hit, output logic have_slot,
                                 output int unsigned slot);
    int unsigned idx;
    logic        seen_tomb;
    int unsigned tomb_at;
    idx       = hash % TABLE_SLOTS;
    seen_tomb = 1'b0;
    tomb_at   = 0;
    hit       = 1'b0;
    have_slot = 1'b0;
    slot      = 0;
    for (int unsigned n = 0; n < TABLE_SLOTS; n++) begin
      if (shadow_live[idx]) begin
        if (shadow_key[idx] == key) begin
          hit       = 1'b1;
          have_slot = 1'b1;
          slot      = idx;
          return;
        end
      end else if (shadow_tomb[idx]) begin
        if (!seen_tomb) begin
          seen_tomb = 1'b1;
          tomb_at   = idx;
        end
      end else begin
        have_slot = 1'b1;
        slot      = seen_tomb ? tomb_at : idx;
        return;
      end
      idx = (idx + 1) % TABLE_SLOTS;
    end
    if (seen_tomb) begin
      have_slot = 1'b1;
      slot      = tomb_at;
    end
  endfunction

  // Apply one request word to the shadow table and return the reply it earns.
  function automatic table_reply_t apply_word(input cmd_e op, input logic [KEY_W-1:0] key,
                                              input logic [HASH_W-1:0] hash,
                                              input logic [VAL_W-1:0] value);
    table_reply_t r;
    logic         hit;
    logic         have_slot;
    int unsigned  at;
    r.status      = ST_OK;
    r.new_key     = 1'b0;
    r.found_value = '0;
    case (op)
      CMD_SET: begin
        // The limit check comes first, so even an existing key is refused.
        if (int'(shadow_fill) + 1 > int'(shadow_limit)) begin
          r.status = ST_FULL;
        end else begin
          locate(key, hash, hit, have_slot, at);
          if (!have_slot) begin
            r.status = ST_FULL;
          end else begin
            if (!hit) begin
              r.new_key = 1'b1;
              if (!shadow_tomb[at]) shadow_fill = shadow_fill + 1'b1;
            end
            shadow_live[at] = 1'b1;
            shadow_tomb[at] = 1'b0;
            shadow_key[at]  = key;
            shadow_val[at]  = value;
          end
        end
      end
      CMD_GET, CMD_DEL: begin
        // With nothing counted there is no walk at all.
        if (shadow_fill == '0) begin
          r.status = ST_ABSENT;
        end else begin
          locate(key, hash, hit, have_slot, at);
          if (!hit) begin
            r.status = ST_ABSENT;
          end else if (op == CMD_GET) begin
            r.found_value = shadow_val[at];
          end else begin
            shadow_live[at] = 1'b0;
            shadow_tomb[at] = 1'b1;
          end
        end
      end
      default: begin
        wipe_table();
      end
    endcase
    return r;
  endfunction

  // Count and report a field mismatch.
  function automatic void note_mismatch(input string field, input logic [VAL_W-1:0] want,
                                        input logic [VAL_W-1:0] got);
    $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
    mismatches++;
  endfunction

  // Watch both channels at every rising edge: compare replies, then predict requests.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wipe_table();
      shadow_limit = LIMIT_RST;
      expected_replies.delete();
      mismatches = 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) shadow_limit = cfg_wdata_i;

      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_replies.size() == 0) begin
          $display("%0t: reply word mismatch, expected none, actual status %0d",
                   $time, rsp_if.status);
          mismatches++;
        end else begin
          oldest = expected_replies.pop_front();
          if (rsp_if.status !== oldest.status)
            note_mismatch("status", VAL_W'(oldest.status), VAL_W'(rsp_if.status));
          if (rsp_if.new_key !== oldest.new_key)
            note_mismatch("new_key", VAL_W'(oldest.new_key), VAL_W'(rsp_if.new_key));
          if (rsp_if.found_value !== oldest.found_value)
            note_mismatch("found_value", oldest.found_value, rsp_if.found_value);
        end
      end

      if (req_if.valid && req_if.ready)
        expected_replies.push_back(apply_word(cmd_e'(req_if.cmd), req_if.key_id,
                                              req_if.key_hash, req_if.set_value));

      pending_o <= expected_replies.size();
    end
  end

endmodule

// File: sim/tb.sv
// Testbench top for the hash table: clock, reset, stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb;
  import oaht_pkg::*;

  localparam int POOL_SIZE   = 64;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASES      = 8;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [LIM_W-1:0] cfg_wdata_i;
  int               fail_count;
  int               pending;

  oaht_req_if req_if ();
  oaht_rsp_if rsp_if ();

  open_addressing_hash_table dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  oaht_table_check u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .req_if       (req_if),
    .rsp_if       (rsp_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Random phases: load limit, word count, idle rates, leading fill burst and
  // the word after which the sender waits for every reply (-1 for none).
  int ph_limit    [PHASES] = '{255, 1, 100, 255, 16, 192, 255, 64};
  int ph_words    [PHASES] = '{300, 100, 200, 300, 150, 150, 300, 250};
  int ph_req_idle [PHASES] = '{18, 18, 18, 66, 66, 66, 0, 0};
  int ph_rsp_idle [PHASES] = '{66, 66, 66, 18, 18, 18, 0, 0};
  int ph_fill     [PHASES] = '{0, 0, 0, 0, 0, 0, 260, 0};
  int ph_drain_at [PHASES] = '{-1, -1, -1, 150, -1, -1, -1, -1};

  int          req_idle_pct;
  int          rsp_idle_pct;
  int unsigned hold_ask;
  int unsigned hold_seen;
  int          n_set, n_get, n_del, n_clr, n_limits;

  // Keys of the well-formed traffic, each with a fixed hash clustered
  // around the top of the table so that chains form and wrap.
  logic [KEY_W-1:0]  pool_key  [POOL_SIZE];
  logic [HASH_W-1:0] pool_hash [POOL_SIZE];

  cmd_e              pick_cmd;
  logic [KEY_W-1:0]  pick_key;
  logic [HASH_W-1:0] pick_hash;
  int                pick;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Give up after a generous fixed time.
  initial begin
    #5_000_000;
    $display("** open_addressing_hash_table: FAILED **");
    $finish;
  end

  // Reply side: random stalls, plus a long hold-off whenever one is asked for.
  initial begin
    hold_seen = 0;
    rsp_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_ask != hold_seen) begin
        hold_seen = hold_ask;
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      rsp_if.ready <= ($urandom_range(99) >= rsp_idle_pct);
    end
  end

  // Offer one request word, with random idle cycles ahead of it, and wait
  // until it is taken.
  task automatic send_word(input cmd_e op, input logic [KEY_W-1:0] key,
                           input logic [HASH_W-1:0] hash, input logic [VAL_W-1:0] value);
    while ($urandom_range(99) < req_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.cmd       <= op;
    req_if.key_id    <= key;
    req_if.key_hash  <= hash;
    req_if.set_value <= value;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    case (op)
      CMD_SET: n_set++;
      CMD_GET: n_get++;
      CMD_DEL: n_del++;
      default: n_clr++;
    endcase
  endtask

  // Stop offering and wait until every expected reply has arrived.
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Write the load limit; only called while the table is idle.
  task automatic write_limit(input int limit);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= LIM_W'(limit);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    n_limits++;
  endtask

  // Fresh set of well-formed keys; zero is kept out of the random keys.
  task automatic refresh_pool();
    for (int k = 0; k < POOL_SIZE; k++) begin
      pool_key[k] = $urandom;
      if (pool_key[k] == '0) pool_key[k] = 1;
      pool_hash[k] = ($urandom & 32'hFFFF_FF00) | ((232 + $urandom_range(23)) % 256);
    end
  endtask

  function automatic logic [VAL_W-1:0] random_value();
    return {$urandom, $urandom};
  endfunction

  // Stimulus and verdict.
  initial begin
    n_set = 0;
    n_get = 0;
    n_del = 0;
    n_clr = 0;
    n_limits = 0;
    hold_ask = 0;
    req_idle_pct = ph_req_idle[0];
    rsp_idle_pct = ph_rsp_idle[0];
    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_wdata_i      <= '0;
    req_if.valid     <= 1'b0;
    req_if.cmd       <= CMD_SET;
    req_if.key_id    <= '0;
    req_if.key_hash  <= '0;
    req_if.set_value <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words under the reset limit: empty table, overwrite, collision,
    // tombstone skip and reuse, key zero, all-ones fields with wrap, clear.
    send_word(CMD_GET, 32'h1, 32'h10, '0);
    send_word(CMD_DEL, 32'h1, 32'h10, '0);
    send_word(CMD_SET, 32'h1, 32'h10, 64'h1111);
    send_word(CMD_SET, 32'h1, 32'h10, 64'h2222);
    send_word(CMD_GET, 32'h1, 32'h10, '0);
    send_word(CMD_SET, 32'h2, 32'h110, 64'h3333);
    send_word(CMD_GET, 32'h2, 32'h110, '0);
    send_word(CMD_DEL, 32'h1, 32'h10, '0);
    send_word(CMD_DEL, 32'h1, 32'h10, '0);
    send_word(CMD_GET, 32'h2, 32'h110, '0);
    send_word(CMD_SET, 32'h3, 32'h210, 64'h4444);
    send_word(CMD_SET, 32'h0, '1, 64'h5555);
    send_word(CMD_GET, 32'h0, '1, '0);
    send_word(CMD_DEL, 32'h0, '1, '0);
    send_word(CMD_SET, '1, '1, '1);
    send_word(CMD_GET, '1, '1, '0);
    send_word(CMD_SET, 32'h3, 32'h210, '0);
    send_word(CMD_CLR, '1, '1, '1);
    send_word(CMD_GET, 32'h2, 32'h110, '0);

    // Smallest limits: one slot, then none at all.
    wait_drained();
    write_limit(1);
    send_word(CMD_SET, 32'h4, 32'h20, 64'h6666);
    send_word(CMD_SET, 32'h5, 32'h21, 64'h7777);
    send_word(CMD_SET, 32'h4, 32'h20, 64'h8888);
    wait_drained();
    write_limit(0);
    send_word(CMD_SET, 32'h6, 32'h22, 64'h9999);
    send_word(CMD_CLR, '0, '0, '0);

    // Random phases, mostly well-formed traffic on the key pool.
    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      write_limit(ph_limit[p]);
      req_idle_pct = ph_req_idle[p];
      rsp_idle_pct = ph_rsp_idle[p];
      refresh_pool();
      if (ph_fill[p] > 0) hold_ask++;
      for (int i = 0; i < ph_words[p]; i++) begin
        pick      = $urandom_range(199);
        pick_cmd  = (pick < 90) ? CMD_SET : (pick < 140) ? CMD_GET :
                    (pick < 198) ? CMD_DEL : CMD_CLR;
        pick      = $urandom_range(POOL_SIZE - 1);
        pick_key  = pool_key[pick];
        pick_hash = pool_hash[pick];
        // Fill bursts and a share of the rest use unrelated keys and hashes.
        if (i < ph_fill[p] || $urandom_range(99) < 15) begin
          pick_key  = $urandom;
          pick_hash = $urandom;
          if (pick_key == '0) pick_key = 1;
        end
        if (i < ph_fill[p]) pick_cmd = CMD_SET;
        send_word(pick_cmd, pick_key, pick_hash, random_value());
        if (i == ph_drain_at[p]) wait_drained();
      end
    end

    wait_drained();
    repeat (40) @(posedge clk_i);
    $display("Covered %0d words: %0d set, %0d get, %0d delete, %0d clear, under %0d limit writes.",
             n_set + n_get + n_del + n_clr, n_set, n_get, n_del, n_clr, n_limits);
    $display("Included a table filled to its limit and a long reply hold-off.");
    if (fail_count == 0 && pending == 0) begin
      $display("** open_addressing_hash_table: PASSED **");
    end else begin
      $display("** open_addressing_hash_table: FAILED **");
    end
    $finish;
  end

endmodule

// File: open_addressing_hash_table.f
sv/oaht_pkg.sv
sv/oaht_if.sv
sv/oaht_ctrl.sv
sv/oaht_dp.sv
sv/open_addressing_hash_table.sv
sim/oaht_table_check.sv
sim/tb.sv
